@@ sv/fpq_pkg.sv @@
// ----------------------------------------------------------------------------
// fpq_pkg: shared types and constants of the fixed-point Q-format ALU
// Operation codes, per-transaction control flags, register map and the
// word mask helper.
// ----------------------------------------------------------------------------
`default_nettype none

package fpq_pkg;

  // Widest word the mask helper covers
  localparam int MAX_WORD_W = 32;

  // Configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 6;
  localparam int FRAC_W    = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_BITS   = 4'd1;

  localparam logic [CFG_W-1:0]  TOTAL_WIDTH_RESET = 6'd32;
  localparam logic [FRAC_W-1:0] FRAC_BITS_RESET   = 5'd16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // Control flags that ride along with each transaction
  typedef struct packed {
    logic is_div;
    logic neg;
    logic dz;
    logic fe;
  } meta_t;

  // Low w bits set
  function automatic logic [MAX_WORD_W-1:0] word_mask(input logic [CFG_W-1:0] w);
    logic [MAX_WORD_W-1:0] m;
    if (w >= CFG_W'(MAX_WORD_W)) begin
      m = '1;
    end else begin
      m = (MAX_WORD_W'(1) << w) - MAX_WORD_W'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ sv/fpq_front.sv @@
// ----------------------------------------------------------------------------
// fpq_front: operand preparation, multiply and product alignment
// Three registered stages: mask and take magnitudes, multiply and form the
// dividend, align the product. Add and subtract finish in the first stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fpq_front #(
  parameter int W  = 32,
  parameter int DW = 63
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [1:0]                 op,
  input  logic [W-1:0]               operand_a,
  input  logic [W-1:0]               operand_b,
  input  logic [fpq_pkg::CFG_W-1:0]  total_width,
  input  logic [fpq_pkg::FRAC_W-1:0] frac_bits,
  output logic                       valid,
  output fpq_pkg::meta_t             meta,
  output logic [DW-1:0]              dvd,
  output logic [W-1:0]               dsr,
  output logic [W-1:0]               pass
);
  import fpq_pkg::*;

  localparam int IDXW = $clog2(W);

  logic [W-1:0]     mask;
  logic [W-1:0]     a_m, b_m, ma_c, mb_c, addsub;
  logic [CFG_W-1:0] wm1;
  logic [IDXW-1:0]  sidx;
  logic             sa, sb, fe_c;
  op_t              op_c;

  // Stage 1 registers
  logic         v1;
  op_t          op1;
  logic [W-1:0] ma1, mb1, pass1;
  logic         neg1, dz1, fe1;

  // Stage 2 registers
  logic          v2;
  op_t           op2;
  logic [2*W-1:0] prod2;
  logic [DW-1:0] dvd2;
  logic [W-1:0]  mb2, pass2;
  logic          neg2, dz2, fe2;

  // Mask operands, take signs and magnitudes
  always_comb begin
    op_c   = op_t'(op);
    mask   = W'(word_mask(total_width));
    fe_c   = (total_width == '0) || (total_width > CFG_W'(W)) ||
             ({1'b0, frac_bits} >= total_width);
    a_m    = operand_a & mask;
    b_m    = operand_b & mask;
    wm1    = total_width - CFG_W'(1);
    sidx   = wm1[IDXW-1:0];
    sa     = a_m[sidx];
    sb     = b_m[sidx];
    ma_c   = sa ? ((~a_m + W'(1)) & mask) : a_m;
    mb_c   = sb ? ((~b_m + W'(1)) & mask) : b_m;
    addsub = (op_c == OP_ADD) ? ((a_m + b_m) & mask) : ((a_m - b_m) & mask);
  end

  // Valid bits of the three stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      v2    <= v1;
      valid <= v2;
    end
  end

  // Payload of the three stages
  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= op_c;
      ma1   <= ma_c;
      mb1   <= mb_c;
      pass1 <= addsub;
      neg1  <= sa ^ sb;
      dz1   <= (op_c == OP_DIV) && (b_m == '0) && !fe_c;
      fe1   <= fe_c;

      op2   <= op1;
      prod2 <= (2*W)'(ma1) * (2*W)'(mb1);
      dvd2  <= DW'(ma1) << frac_bits;
      mb2   <= mb1;
      pass2 <= pass1;
      neg2  <= neg1;
      dz2   <= dz1;
      fe2   <= fe1;

      pass        <= (op2 == OP_MUL) ? (W'(prod2 >> frac_bits) & mask) : pass2;
      dvd         <= dvd2;
      dsr         <= mb2;
      meta.is_div <= (op2 == OP_DIV);
      meta.neg    <= neg2 && ((op2 == OP_MUL) || (op2 == OP_DIV));
      meta.dz     <= dz2;
      meta.fe     <= fe2;
    end
  end

endmodule

`default_nettype wire

@@ sv/fpq_div_cell.sv @@
// ----------------------------------------------------------------------------
// fpq_div_cell: one restoring division cell
// Brings down one dividend bit, trial-subtracts the divisor and shifts one
// quotient bit in, then hands everything to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module fpq_div_cell #(
  parameter int W  = 32,
  parameter int DW = 63
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  fpq_pkg::meta_t in_meta,
  input  logic [W-1:0]   in_rem,
  input  logic [DW-1:0]  in_dvd,
  input  logic [W-1:0]   in_quo,
  input  logic [W-1:0]   in_dsr,
  input  logic [W-1:0]   in_pass,
  output logic           valid,
  output fpq_pkg::meta_t meta,
  output logic [W-1:0]   rem,
  output logic [DW-1:0]  dvd,
  output logic [W-1:0]   quo,
  output logic [W-1:0]   dsr,
  output logic [W-1:0]   pass
);
  import fpq_pkg::*;

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_next;

  // Trial subtract
  always_comb begin
    trial    = {in_rem, in_dvd[DW-1]};
    diff     = trial - {1'b0, in_dsr};
    ge       = trial >= {1'b0, in_dsr};
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= in_valid;
    end
  end

  // Advance the partial remainder and quotient
  always_ff @(posedge clk) begin
    if (en) begin
      meta <= in_meta;
      rem  <= rem_next;
      dvd  <= in_dvd << 1;
      quo  <= {in_quo[W-2:0], ge};
      dsr  <= in_dsr;
      pass <= in_pass;
    end
  end

endmodule

`default_nettype wire

@@ sv/fixed_point_q_format_alu.sv @@
// ----------------------------------------------------------------------------
// fixed_point_q_format_alu: signed Q-format add, subtract, multiply, divide
// Top level: configuration registers, front stages, division cell row and
// the sign/flag output stage.
// ----------------------------------------------------------------------------
// The ALU takes one transaction per cycle while in_stall is low and
// returns each result in order. Every operation passes through three
// front stages (mask, multiply, align), the row of 2*MAX_WIDTH-1 division
// cells, one quotient bit per cell, and the output register. A stalled
// output holds the whole pipeline and raises in_stall. Write total_width and
// frac_bits only while no transaction is in flight.
`default_nettype none

module fixed_point_q_format_alu #(
  parameter int MAX_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [MAX_WIDTH-1:0]          operand_a,
  input  logic [MAX_WIDTH-1:0]          operand_b,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fpq_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [MAX_WIDTH-1:0]          result,
  output logic                          div_by_zero,
  output logic                          format_error
);
  import fpq_pkg::*;

  localparam int W  = MAX_WIDTH;
  localparam int DW = 2 * MAX_WIDTH - 1;

  logic [CFG_W-1:0]  total_width;
  logic [FRAC_W-1:0] frac_bits;
  logic              en;

  logic          c_valid [0:DW];
  meta_t         c_meta  [0:DW];
  logic [W-1:0]  c_rem   [0:DW];
  logic [DW-1:0] c_dvd   [0:DW];
  logic [W-1:0]  c_quo   [0:DW];
  logic [W-1:0]  c_dsr   [0:DW];
  logic [W-1:0]  c_pass  [0:DW];

  logic [W-1:0] mask, mag, res_c;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_width <= TOTAL_WIDTH_RESET;
      frac_bits   <= FRAC_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_TOTAL_WIDTH) begin
        total_width <= cfg_data;
      end else if (cfg_index == REG_FRAC_BITS) begin
        frac_bits <= cfg_data[FRAC_W-1:0];
      end
    end
  end

  // Hold every stage while the output transaction waits
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  fpq_front #(.W(W), .DW(DW)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .op         (op),
    .operand_a  (operand_a),
    .operand_b  (operand_b),
    .total_width(total_width),
    .frac_bits  (frac_bits),
    .valid      (c_valid[0]),
    .meta       (c_meta[0]),
    .dvd        (c_dvd[0]),
    .dsr        (c_dsr[0]),
    .pass       (c_pass[0])
  );

  assign c_rem[0] = '0;
  assign c_quo[0] = '0;

  // Division cell row
  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpq_div_cell #(.W(W), .DW(DW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .in_valid(c_valid[i]),
      .in_meta (c_meta[i]),
      .in_rem  (c_rem[i]),
      .in_dvd  (c_dvd[i]),
      .in_quo  (c_quo[i]),
      .in_dsr  (c_dsr[i]),
      .in_pass (c_pass[i]),
      .valid   (c_valid[i+1]),
      .meta    (c_meta[i+1]),
      .rem     (c_rem[i+1]),
      .dvd     (c_dvd[i+1]),
      .quo     (c_quo[i+1]),
      .dsr     (c_dsr[i+1]),
      .pass    (c_pass[i+1])
    );
  end

  // Apply sign and flags
  always_comb begin
    mask  = W'(word_mask(total_width));
    mag   = (c_meta[DW].is_div ? c_quo[DW] : c_pass[DW]) & mask;
    res_c = c_meta[DW].neg ? ((~mag + W'(1)) & mask) : mag;
    if (c_meta[DW].fe || c_meta[DW].dz) begin
      res_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_valid[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result       <= res_c;
      div_by_zero  <= c_meta[DW].dz;
      format_error <= c_meta[DW].fe;
    end
  end

  // Checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(div_by_zero && format_error))
    else $error("div_by_zero and format_error both set");

  a_flag_zero_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (div_by_zero || format_error)) |-> (result == '0))
    else $error("flagged result is not zero");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result)))
    else $error("stalled result changed");

  a_cfg_width_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_TOTAL_WIDTH)) |=>
      (total_width == $past(cfg_data)))
    else $error("total_width write lost");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fixed-point Q-format ALU
// Drives directed and random transactions through the ALU under several
// Q formats, including the unusable ones. The bench computes each expected
// result with its own fixed-point model and compares every output transaction
// against it in order. Both sides idle at random, and there is one long
// output hold-off and one drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import fpq_pkg::*;

  localparam int W        = 32;
  localparam int LATENCY  = 2 * W + 3;
  localparam int N_RANDOM = 950;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [W-1:0] res;
    logic         dz;
    logic         fe;
  } alu_out_t;

  typedef struct {
    op_t          opc;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         known;
    alu_out_t     fixed;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] op;
  logic [W-1:0] operand_a;
  logic [W-1:0] operand_b;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic out_valid;
  logic out_stall;
  logic [W-1:0] result;
  logic div_by_zero;
  logic format_error;

  logic [5:0] q_width;
  logic [4:0] q_frac;
  alu_out_t expected_q[$];
  int errors;
  longint cycles;
  bit hold_output;

  fixed_point_q_format_alu #(.MAX_WIDTH(W)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .operand_a(operand_a), .operand_b(operand_b),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .div_by_zero(div_by_zero), .format_error(format_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Two's complement negate within the low w bits
  function automatic logic [63:0] neg_in_word(logic [63:0] v, logic [63:0] m);
    return (~v + 64'd1) & m;
  endfunction

  // Expected output of one transaction under the current Q format
  function automatic alu_out_t compute_q_op(op_t opc, logic [W-1:0] ai, logic [W-1:0] bi);
    alu_out_t r;
    logic [63:0] m, a, b, ma, mb, x;
    logic sa, sb;
    r.res = '0;
    r.dz = 1'b0;
    r.fe = 1'b0;
    if (q_width == 0 || q_width > W || {1'b0, q_frac} >= q_width) begin
      r.fe = 1'b1;
      return r;
    end
    m = (64'd1 << q_width) - 64'd1;
    a = {32'd0, ai} & m;
    b = {32'd0, bi} & m;
    case (opc)
      OP_ADD: r.res = W'((a + b) & m);
      OP_SUB: r.res = W'((a + neg_in_word(b, m)) & m);
      default: begin
        if (opc == OP_DIV && b == 0) begin
          r.dz = 1'b1;
        end else begin
          sa = a[q_width - 1];
          sb = b[q_width - 1];
          ma = sa ? neg_in_word(a, m) : a;
          mb = sb ? neg_in_word(b, m) : b;
          if (opc == OP_MUL) x = (ma * mb) >> q_frac;
          else x = (ma << q_frac) / mb;
          x &= m;
          if (sa != sb) x = neg_in_word(x, m);
          r.res = W'(x);
        end
      end
    endcase
    return r;
  endfunction

  // Cycle counter and timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Output side: random stalls, long hold-off on request, compare transactions
  initial begin
    int gap;
    alu_out_t e;
    out_stall = 1'b1;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, result);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (result !== e.res) begin
            $display("%0t: result expected %h actual %h", $time, e.res, result);
            errors++;
          end
          if (div_by_zero !== e.dz) begin
            $display("%0t: div_by_zero expected %b actual %b", $time, e.dz, div_by_zero);
            errors++;
          end
          if (format_error !== e.fe) begin
            $display("%0t: format_error expected %b actual %b", $time, e.fe, format_error);
            errors++;
          end
        end
      end
      // Hold off for a long stretch when asked
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
        out_stall <= 1'b0;
      end else if (rst) begin
        out_stall <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 9) == 0)
          gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
    end
  end

  // Write one configuration register
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_TOTAL_WIDTH) q_width = val;
    else if (idx == REG_FRAC_BITS) q_frac = val[4:0];
  endtask

  // Wait until every expected result has arrived, then let the pipe settle
  task automatic drain;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Offer one transaction and hold it until accepted
  task automatic send_op(op_t opc, logic [W-1:0] a, logic [W-1:0] b);
    in_valid  <= 1'b1;
    op        <= opc;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q.push_back(compute_q_op(opc, a, b));
  endtask

  // Random idle gap on the input side
  task automatic input_gap(bit idle);
    int n;
    if (!idle || $urandom_range(0, 5) != 0) return;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random operand: mostly the edges of the word, otherwise anything
  function automatic logic [W-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return W'(1) << (q_width == 0 ? 0 : q_width - 1);
      3: return W'(1) << q_frac;
      4: return W'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  stim_row_t dir_rows[$];

  task automatic add_row(op_t o, logic [W-1:0] a, logic [W-1:0] b, logic k,
                         logic [W-1:0] r, logic dz, logic fe);
    stim_row_t s;
    s.opc = o; s.a = a; s.b = b; s.known = k;
    s.fixed.res = r; s.fixed.dz = dz; s.fixed.fe = fe;
    dir_rows.push_back(s);
  endtask

  initial begin
    int n, phase, idx;
    alu_out_t e;
    logic [5:0] widths[7];
    logic [4:0] fracs[7];
    rst = 1'b1;
    in_valid = 1'b0; op = '0; operand_a = '0; operand_b = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    q_width = TOTAL_WIDTH_RESET;
    q_frac = FRAC_BITS_RESET;
    errors = 0; hold_output = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table under the reset format Q16.16
    add_row(OP_ADD, 32'h0001_0000, 32'h0001_0000, 1, 32'h0002_0000, 0, 0);
    add_row(OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1, 32'h8000_0000, 0, 0);
    add_row(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFE, 0, 0);
    add_row(OP_SUB, 32'h0000_0000, 32'h0000_0001, 1, 32'hFFFF_FFFF, 0, 0);
    add_row(OP_SUB, 32'h8000_0000, 32'h0000_0001, 1, 32'h7FFF_FFFF, 0, 0);
    add_row(OP_MUL, 32'h0002_0000, 32'h0003_0000, 1, 32'h0006_0000, 0, 0);
    add_row(OP_MUL, 32'hFFFE_0000, 32'h0003_0000, 1, 32'hFFFA_0000, 0, 0);
    add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, '0, 0, 0);
    add_row(OP_MUL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, '0, 0, 0);
    add_row(OP_DIV, 32'h0006_0000, 32'h0002_0000, 1, 32'h0003_0000, 0, 0);
    add_row(OP_DIV, 32'h1234_5678, 32'h0000_0000, 1, 32'h0000_0000, 1, 0);
    add_row(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 0, '0, 0, 0);
    add_row(OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001, 0, '0, 0, 0);
    add_row(OP_DIV, 32'hFFFF_0000, 32'h0000_0003, 0, '0, 0, 0);
    for (int i = 0; i < dir_rows.size(); i++) begin
      send_op(dir_rows[i].opc, dir_rows[i].a, dir_rows[i].b);
      if (dir_rows[i].known) begin
        e = expected_q[$];
        if (e != dir_rows[i].fixed) begin
          $display("%0t: table row %0d expected %h actual %h", $time, i,
                   dir_rows[i].fixed.res, e.res);
          errors++;
        end
      end
    end
    in_valid <= 1'b0;
    drain();

    // Bad formats: frac not below width, a zero width and a width above W
    write_reg(REG_FRAC_BITS, 6'd31);
    write_reg(REG_TOTAL_WIDTH, 6'd31);
    send_op(OP_DIV, 32'h5, 32'h0);
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'h1);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_TOTAL_WIDTH, 6'd0);
    write_reg(REG_FRAC_BITS, 6'd0);
    send_op(OP_MUL, 32'h3, 32'h3);
    in_valid <= 1'b0;
    drain();
    write_reg(REG_TOTAL_WIDTH, 6'd33);
    send_op(OP_SUB, 32'h3, 32'h1);
    in_valid <= 1'b0;
    drain();

    // Random phases across several formats, extremes among them
    widths = '{6'd32, 6'd1, 6'd32, 6'd8, 6'd16, 6'd13, 6'd32};
    fracs  = '{5'd0, 5'd0, 5'd31, 5'd4, 5'd15, 5'd13, 5'd16};
    n = N_RANDOM / 7;
    for (phase = 0; phase < 7; phase++) begin
      write_reg(REG_TOTAL_WIDTH, widths[phase]);
      write_reg(REG_FRAC_BITS, {1'b0, fracs[phase]});
      for (idx = 0; idx < n; idx++) begin
        if (phase == 2 && idx == 20) hold_output = 1'b1;
        if (phase == 4 && idx == 60) begin
          in_valid <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk);
        end
        input_gap(phase != 6 || idx > 50);
        send_op(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
      end
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
